// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int RW = 7;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_PEEK    = 3'd1;
    localparam logic [2:0] ACT_EXTRACT = 3'd2;
    localparam logic [2:0] ACT_KTH     = 3'd3;
    localparam logic [2:0] ACT_DELETE  = 3'd4;
    localparam logic [2:0] ACT_REPLACE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANK0 = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PEEK,
        S_EX2,
        S_FIND_RD,
        S_FIND_CMP,
        S_DEL_LD,
        S_SU_RD,
        S_SU_CMP,
        S_SD_RD,
        S_SD_RL,
        S_SD_RR,
        S_SD_MV,
        S_CP,
        S_K_LOOP,
        S_K_LD,
        S_K_OUT,
        S_FIN
    } t_state;

endpackage

// ===== rtl/mhpq_ram.sv =====
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue, one item at a time, one result per item.
// Peek reads the root; insert sifts up and extract sifts down, one heap level at a time.
// Delete/replace add a linear key scan over the stored entries before sifting.
// K-th largest copies the heap to a scratch RAM, then rank-1 sift-downs.
// The heap and scratch RAMs share one read address; no new item until the result is out.
// Reset (synchronous, active low) empties the heap; RAM contents are not cleared.
module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_new_key,
    input  logic [RW-1:0]      i_rank,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [32:0] o_value,
    output logic [1:0]         o_status
);

    t_state r_state, n_state;
    logic [2:0] r_act, n_act;
    logic signed [31:0] r_key, n_key, r_nkey, n_nkey, r_cur, n_cur, r_bigv, n_bigv;
    logic [RW-1:0] r_rank, n_rank, r_j, n_j;
    logic [CW-1:0] r_occ, n_occ, r_n, n_n, r_i, n_i, r_pos, n_pos, r_bigi, n_bigi;
    logic r_sel, n_sel;
    logic signed [32:0] r_res_val, n_res_val, r_oval, n_oval;
    logic [1:0] r_res_st, n_res_st, r_ost, n_ost;
    logic r_ovalid, n_ovalid;

    logic [31:0] heap_rd, scr_rd;
    logic signed [31:0] rd;
    logic mem_we;
    logic [AW-1:0] mem_wa, rd_addr, hi, par;
    logic [31:0] mem_wd;
    logic [IW-1:0] lft, rgt;
    logic signed [32:0] diff, absdiff;
    logic full, rank_big;
    t_state su_end_st, sd_end_st;

    assign rd       = r_sel ? $signed(scr_rd) : $signed(heap_rd);
    assign hi       = r_i[AW-1:0];
    assign par      = AW'((r_i - CW'(1)) >> 1);
    assign lft      = (IW'(r_i) << 1) | IW'(1);
    assign rgt      = lft + IW'(1);
    assign diff     = 33'(r_key) - 33'(r_nkey);
    assign absdiff  = diff[32] ? -diff : diff;
    assign full     = (r_occ == CW'(CAPACITY));
    assign rank_big = (32'(i_rank) > 32'(r_occ));
    assign su_end_st = (r_act == ACT_DELETE && r_i == r_pos) ? S_SD_RD : S_FIN;
    assign sd_end_st = (r_act == ACT_KTH) ? S_K_LOOP : S_FIN;

    mhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_heap (
        .i_clk  (i_clk),
        .i_we   (mem_we && !r_sel),
        .i_waddr(mem_wa),
        .i_wdata(mem_wd),
        .i_raddr(rd_addr),
        .o_rdata(heap_rd)
    );

    mhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_scratch (
        .i_clk  (i_clk),
        .i_we   (mem_we && r_sel),
        .i_waddr(mem_wa),
        .i_wdata(mem_wd),
        .i_raddr(rd_addr),
        .o_rdata(scr_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_action) inside
                        ACT_INSERT: n_state = full ? S_FIN : S_SU_RD;
                        ACT_PEEK, ACT_EXTRACT: n_state = (r_occ == '0) ? S_FIN : S_PEEK;
                        ACT_KTH: n_state = (i_rank == '0 || rank_big) ? S_FIN : S_CP;
                        ACT_DELETE, ACT_REPLACE: n_state = S_FIND_RD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_PEEK:     n_state = (r_act == ACT_EXTRACT) ? S_EX2 : S_FIN;
            S_EX2:      n_state = S_SD_RD;
            S_FIND_RD:  n_state = (r_i == r_occ) ? S_FIN : S_FIND_CMP;
            S_FIND_CMP: begin
                if (rd == r_key) begin
                    if (r_act == ACT_DELETE) begin
                        n_state = (r_i == r_occ - CW'(1)) ? S_FIN : S_DEL_LD;
                    end else begin
                        n_state = (r_key < r_nkey) ? S_SU_RD : S_SD_RD;
                    end
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_DEL_LD:   n_state = S_SU_RD;
            S_SU_RD:    n_state = (r_i == '0) ? su_end_st : S_SU_CMP;
            S_SU_CMP:   n_state = (rd < r_cur) ? S_SU_RD : su_end_st;
            S_SD_RD:    n_state = (lft < IW'(r_n)) ? S_SD_RL : sd_end_st;
            S_SD_RL:    n_state = (rgt < IW'(r_n)) ? S_SD_RR : S_SD_MV;
            S_SD_RR:    n_state = S_SD_MV;
            S_SD_MV:    n_state = (r_bigi == r_i) ? sd_end_st : S_SD_RD;
            S_CP:       n_state = (r_i == r_occ) ? S_K_LOOP : S_CP;
            S_K_LOOP:   n_state = (r_j == r_rank) ? S_K_OUT : S_K_LD;
            S_K_LD:     n_state = S_SD_RD;
            S_K_OUT:    n_state = S_FIN;
            S_FIN:      n_state = (!r_ovalid || !i_stall) ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_act = r_act;
        n_key = r_key;
        n_nkey = r_nkey;
        n_rank = r_rank;
        n_cur = r_cur;
        n_bigv = r_bigv;
        n_bigi = r_bigi;
        n_j = r_j;
        n_occ = r_occ;
        n_n = r_n;
        n_i = r_i;
        n_pos = r_pos;
        n_sel = r_sel;
        n_res_val = r_res_val;
        n_res_st = r_res_st;
        n_ovalid = r_ovalid && i_stall;
        n_oval = r_oval;
        n_ost = r_ost;
        mem_we = 1'b0;
        mem_wa = hi;
        mem_wd = r_cur;
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act = i_action;
                    n_key = i_key;
                    n_nkey = i_new_key;
                    n_rank = i_rank;
                    n_res_val = '0;
                    n_res_st = ST_OK;
                    n_sel = 1'b0;
                    n_i = '0;
                    case (i_action) inside
                        ACT_INSERT: begin
                            if (full) begin
                                n_res_st = ST_FULL;
                            end else begin
                                n_cur = i_key;
                                n_i = r_occ;
                                n_occ = r_occ + CW'(1);
                            end
                        end
                        ACT_PEEK, ACT_EXTRACT: begin
                            if (r_occ == '0) begin
                                n_res_val = '1;
                                n_res_st = ST_MISS;
                            end
                        end
                        ACT_KTH: begin
                            if (i_rank == '0) begin
                                n_res_st = ST_RANK0;
                            end else if (rank_big) begin
                                n_res_val = '1;
                                n_res_st = ST_MISS;
                            end else begin
                                n_sel = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PEEK: begin
                n_res_val = 33'(rd);
                if (r_act == ACT_EXTRACT) begin
                    n_occ = r_occ - CW'(1);
                    n_n = r_occ - CW'(1);
                    rd_addr = AW'(r_occ - CW'(1));
                end
            end
            S_EX2: begin
                n_cur = rd;
                n_i = '0;
            end
            S_FIND_RD: begin
                if (r_i == r_occ) begin
                    n_res_val = (r_act == ACT_DELETE) ? '1 : absdiff;
                    n_res_st = ST_MISS;
                end else begin
                    rd_addr = hi;
                end
            end
            S_FIND_CMP: begin
                if (rd == r_key) begin
                    n_pos = r_i;
                    if (r_act == ACT_DELETE) begin
                        n_occ = r_occ - CW'(1);
                        n_n = r_occ - CW'(1);
                        rd_addr = AW'(r_occ - CW'(1));
                    end else begin
                        n_cur = r_nkey;
                        n_n = r_occ;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_DEL_LD: begin
                n_cur = rd;
                n_i = r_pos;
            end
            S_SU_RD: begin
                if (r_i == '0) begin
                    mem_we = 1'b1;
                end else begin
                    rd_addr = par;
                end
            end
            S_SU_CMP: begin
                mem_we = 1'b1;
                if (rd < r_cur) begin
                    mem_wd = rd;
                    n_i = CW'(par);
                end
            end
            S_SD_RD: begin
                if (lft < IW'(r_n)) begin
                    rd_addr = AW'(lft);
                end else begin
                    mem_we = 1'b1;
                    n_j = r_j + RW'(1);
                end
            end
            S_SD_RL: begin
                if (r_cur < rd) begin
                    n_bigv = rd;
                    n_bigi = CW'(lft);
                end else begin
                    n_bigv = r_cur;
                    n_bigi = r_i;
                end
                if (rgt < IW'(r_n)) begin
                    rd_addr = AW'(rgt);
                end
            end
            S_SD_RR: begin
                if (r_bigv < rd) begin
                    n_bigv = rd;
                    n_bigi = CW'(rgt);
                end
            end
            S_SD_MV: begin
                mem_we = 1'b1;
                if (r_bigi == r_i) begin
                    n_j = r_j + RW'(1);
                end else begin
                    mem_wd = r_bigv;
                    n_i = r_bigi;
                end
            end
            S_CP: begin
                rd_addr = hi;
                if (r_i != '0) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(r_i - CW'(1));
                    mem_wd = heap_rd;
                end
                if (r_i == r_occ) begin
                    n_n = r_occ;
                    n_j = RW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_K_LOOP: begin
                if (r_j != r_rank) begin
                    n_n = r_n - CW'(1);
                    rd_addr = AW'(r_n - CW'(1));
                end
            end
            S_K_LD: begin
                n_cur = rd;
                n_i = '0;
            end
            S_K_OUT: begin
                n_res_val = 33'(rd);
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oval = r_res_val;
                    n_ost = r_res_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ <= n_occ;
            r_ovalid <= n_ovalid;
        end
        r_act <= n_act;
        r_key <= n_key;
        r_nkey <= n_nkey;
        r_rank <= n_rank;
        r_cur <= n_cur;
        r_bigv <= n_bigv;
        r_bigi <= n_bigi;
        r_j <= n_j;
        r_n <= n_n;
        r_i <= n_i;
        r_pos <= n_pos;
        r_sel <= n_sel;
        r_res_val <= n_res_val;
        r_res_st <= n_res_st;
        r_oval <= n_oval;
        r_ost <= n_ost;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_value  = r_oval;
    assign o_status = r_ost;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_INSERT && !full)
        |=> r_occ == $past(r_occ) + CW'(1))
        else $error("insert did not grow occupancy");

    a_rank0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_RANK0 || o_status == ST_FULL)) |-> o_value == '0)
        else $error("nonzero value with rank-zero or full status");

    a_busy_no_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN && r_state != S_IDLE && !r_ovalid) |=> !r_ovalid)
        else $error("result presented before sequence finished");

endmodule

// ===== bench/max_heap_priority_queue_tb.sv =====
module max_heap_priority_queue_tb import mhpq_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [RW-1:0]      rank;
        logic               has_fixed;
        logic signed [32:0] fixed_value;
        logic [1:0]         fixed_status;
    } t_row;

    typedef struct packed {
        logic signed [32:0] value;
        logic [1:0]         status;
    } t_res;

    localparam int LIMIT = 10000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_action = '0;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_new_key = '0;
    logic [RW-1:0]      i_rank = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [32:0] o_value;
    logic [1:0]         o_status;

    max_heap_priority_queue u_top (.*);

    always #5 i_clk = ~i_clk;

    logic signed [31:0] heap_mdl [CAPACITY];
    int                 count_mdl;
    t_res               pending_q [$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 n_items = 0;
    int                 n_results = 0;
    int                 n_miss = 0;
    int                 n_full = 0;
    int                 out_wait = 0;

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void sift_up_mdl(ref logic signed [31:0] a [CAPACITY], input int i);
        int p;
        logic signed [31:0] t;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (a[p] < a[i]) begin
                t = a[p]; a[p] = a[i]; a[i] = t;
                i = p;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down_mdl(ref logic signed [31:0] a [CAPACITY],
                                          input int n, input int i);
        int big, l, r;
        logic signed [31:0] t;
        forever begin
            big = i; l = 2 * i + 1; r = 2 * i + 2;
            if (l < n && a[big] < a[l]) big = l;
            if (r < n && a[big] < a[r]) big = r;
            if (big == i) break;
            t = a[i]; a[i] = a[big]; a[big] = t;
            i = big;
        end
    endfunction

    function automatic int find_mdl(input logic signed [31:0] k);
        for (int i = 0; i < count_mdl; i++)
            if (heap_mdl[i] == k) return i;
        return -1;
    endfunction

    function automatic t_res heap_op(input logic [2:0] act, input logic signed [31:0] k,
                                     input logic signed [31:0] nk, input int rk);
        t_res r;
        int pos, n;
        logic signed [31:0] scr [CAPACITY];
        longint d;
        r.value = '0;
        r.status = ST_OK;
        case (act)
            ACT_INSERT: begin
                if (count_mdl >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mdl[count_mdl] = k;
                    sift_up_mdl(heap_mdl, count_mdl);
                    count_mdl++;
                end
            end
            ACT_PEEK, ACT_EXTRACT: begin
                if (count_mdl == 0) begin
                    r.value = -1; r.status = ST_MISS;
                end else begin
                    r.value = heap_mdl[0];
                    if (act == ACT_EXTRACT) begin
                        count_mdl--;
                        heap_mdl[0] = heap_mdl[count_mdl];
                        sift_down_mdl(heap_mdl, count_mdl, 0);
                    end
                end
            end
            ACT_KTH: begin
                if (rk == 0) begin
                    r.status = ST_RANK0;
                end else if (rk > count_mdl) begin
                    r.value = -1; r.status = ST_MISS;
                end else begin
                    scr = heap_mdl;
                    n = count_mdl;
                    for (int j = 1; j < rk; j++) begin
                        n--;
                        scr[0] = scr[n];
                        sift_down_mdl(scr, n, 0);
                    end
                    r.value = scr[0];
                end
            end
            ACT_DELETE: begin
                pos = find_mdl(k);
                if (pos < 0) begin
                    r.value = -1; r.status = ST_MISS;
                end else begin
                    count_mdl--;
                    if (pos != count_mdl) begin
                        heap_mdl[pos] = heap_mdl[count_mdl];
                        sift_up_mdl(heap_mdl, pos);
                        sift_down_mdl(heap_mdl, count_mdl, pos);
                    end
                end
            end
            ACT_REPLACE: begin
                pos = find_mdl(k);
                if (pos < 0) begin
                    d = longint'(k) - longint'(nk);
                    if (d < 0) d = -d;
                    r.value = d[32:0];
                    r.status = ST_MISS;
                end else begin
                    heap_mdl[pos] = nk;
                    if (k < nk) sift_up_mdl(heap_mdl, pos);
                    else if (k > nk) sift_down_mdl(heap_mdl, count_mdl, pos);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_row mk(input logic [2:0] a, input logic signed [31:0] k,
                                input logic signed [31:0] nk, input int rk,
                                input bit fx = 0, input logic signed [32:0] fv = 0,
                                input logic [1:0] fs = 0);
        t_row r;
        r.action = a; r.key = k; r.new_key = nk; r.rank = rk[RW-1:0];
        r.has_fixed = fx; r.fixed_value = fv; r.fixed_status = fs;
        return r;
    endfunction

    t_row directed [$];
    int   pool [$];

    function automatic logic signed [31:0] pick_key();
        if (pool.size() > 0 && $urandom_range(0, 2) != 0)
            return pool[$urandom_range(0, pool.size() - 1)];
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 31) - 16;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input t_row r);
        t_res e;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        e = heap_op(r.action, r.key, r.new_key, int'(r.rank));
        if (r.has_fixed && (e.value !== r.fixed_value || e.status !== r.fixed_status))
            report($sformatf("table row act %0d: predictor gives %0d/%0d, row says %0d/%0d",
                             r.action, e.value, e.status, r.fixed_value, r.fixed_status));
        if (r.has_fixed) begin
            e.value = r.fixed_value;
            e.status = r.fixed_status;
        end
        if (e.status == ST_MISS) n_miss++;
        if (e.status == ST_FULL) n_full++;
        pending_q.push_back(e);
        if (r.action == ACT_INSERT) pool.push_back(r.key);
        if (r.action == ACT_REPLACE) pool.push_back(r.new_key);
        if (pool.size() > 64) void'(pool.pop_front());
        i_action <= r.action; i_key <= r.key; i_new_key <= r.new_key; i_rank <= r.rank;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            out_wait = $urandom_range(0, 15);
        end else if (o_valid && out_wait > 0) begin
            i_stall <= 1'b1;
            out_wait--;
        end else begin
            if (o_valid) out_wait = $urandom_range(0, 15);
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result %0d/%0d", o_value, o_status));
            end else begin
                e = pending_q.pop_front();
                if (o_value !== e.value)
                    report($sformatf("value got %0d want %0d", o_value, e.value));
                if (o_status !== e.status)
                    report($sformatf("status got %0d want %0d", o_status, e.status));
            end
        end
    end

    initial begin
        t_row r;
        int mode, a;
        count_mdl = 0;
        foreach (heap_mdl[i]) heap_mdl[i] = '0;
        directed.push_back(mk(ACT_PEEK, 0, 0, 0, 1, -1, ST_MISS));
        directed.push_back(mk(ACT_EXTRACT, 0, 0, 0, 1, -1, ST_MISS));
        directed.push_back(mk(ACT_KTH, 0, 0, 0, 1, 0, ST_RANK0));
        directed.push_back(mk(ACT_KTH, 0, 0, 1, 1, -1, ST_MISS));
        directed.push_back(mk(ACT_DELETE, 5, 0, 0, 1, -1, ST_MISS));
        directed.push_back(mk(ACT_REPLACE, 32'h7fffffff, 32'h80000000, 0,
                              1, 33'h0ffffffff, ST_MISS));
        directed.push_back(mk(ACT_INSERT, 32'h80000000, 0, 0, 1, 0, ST_OK));
        directed.push_back(mk(ACT_INSERT, 32'h7fffffff, 0, 0, 1, 0, ST_OK));
        directed.push_back(mk(ACT_PEEK, 0, 0, 0, 1, 33'sd2147483647, ST_OK));
        directed.push_back(mk(ACT_INSERT, 7, 0, 0));
        directed.push_back(mk(ACT_INSERT, 7, 0, 0));
        directed.push_back(mk(ACT_INSERT, -3, 0, 0));
        directed.push_back(mk(ACT_KTH, 0, 0, 3));
        directed.push_back(mk(ACT_KTH, 0, 0, 64));
        directed.push_back(mk(ACT_REPLACE, 7, 100, 0));
        directed.push_back(mk(ACT_REPLACE, 32'h7fffffff, -50, 0));
        directed.push_back(mk(ACT_DELETE, 7, 0, 0));
        directed.push_back(mk(ACT_DELETE, 32'h80000000, 0, 0));
        directed.push_back(mk(ACT_EXTRACT, 0, 0, 0));
        directed.push_back(mk(3'd6, 1, 1, 1, 1, 0, ST_OK));
        directed.push_back(mk(3'd7, -1, -1, 127, 1, 0, ST_OK));
        directed.push_back(mk(ACT_KTH, 0, 0, 127));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send(directed[i]);
        // fill to capacity, hit full, then drain
        for (int i = 0; i < CAPACITY + 2; i++) send(mk(ACT_INSERT, pick_key(), 0, 0));
        send(mk(ACT_KTH, 0, 0, CAPACITY));
        drain();
        for (int i = 0; i < CAPACITY + 1; i++) send(mk(ACT_EXTRACT, 0, 0, 0));
        for (int i = 0; i < 700; i++) begin
            mode = $urandom_range(0, 99);
            if (mode < 2) begin
                a = $urandom_range(6, 7);
                send(mk(3'(a), $urandom, $urandom, $urandom_range(0, 127)));
                continue;
            end
            if (count_mdl < 8) a = $urandom_range(0, 2) ? ACT_INSERT : $urandom_range(1, 5);
            else if (count_mdl > 56) a = $urandom_range(1, 5);
            else a = $urandom_range(0, 5);
            r = mk(3'(a), pick_key(), pick_key(), 0);
            if (a == ACT_KTH)
                r.rank = $urandom_range(0, 7) == 0 ? RW'($urandom_range(0, 127))
                                                   : RW'($urandom_range(0, count_mdl + 1));
            if (a != ACT_KTH && $urandom_range(0, 1)) r.rank = RW'($urandom);
            send(r);
            if (i == 350) drain();
        end
        drain();
        repeat (300) @(posedge i_clk);
        $display("sent %0d items, checked %0d results (%0d miss, %0d full)",
                 n_items, n_results, n_miss, n_full);
        $display("covered all actions, empty/full/rank-zero cases and random stalls");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
